/* rtl/core/ser_pkg.sv */
// Package for the sonar echo ranger: item structs, mode and source codes,
// register indexes, reset values and the Q8 scaling constant.
// No dependencies.
package ser_pkg;

  typedef enum logic [1:0] {
    MODE_TICK     = 2'd0,
    MODE_OVERFLOW = 2'd1,
    MODE_ECHO     = 2'd2,
    MODE_READ     = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    SRC_FRESH    = 2'd0,
    SRC_PREVIOUS = 2'd1,
    SRC_FALLBACK = 2'd2
  } source_t;

  typedef enum logic [2:0] {
    REG_MIN_TICKS      = 3'd0,
    REG_MAX_TICKS      = 3'd1,
    REG_ERROR_LIMIT    = 3'd2,
    REG_FALLBACK_TICKS = 3'd3,
    REG_COMPARES       = 3'd4
  } reg_idx_t;

  typedef struct packed {
    mode_t       mode;
    logic        echo_level;
    logic [15:0] timer_count;
  } in_item_t;

  typedef struct packed {
    logic        trigger_level;
    logic        reading_ready;
    logic [17:0] distance_q8;
    source_t     source;
  } out_item_t;

  localparam int unsigned ADDR_W = 5;

  localparam logic [15:0] MIN_TICKS_RST      = 16'd590;
  localparam logic [15:0] MAX_TICKS_RST      = 16'd59000;
  localparam logic [7:0]  ERROR_LIMIT_RST    = 8'd50;
  localparam logic [15:0] FALLBACK_TICKS_RST = 16'd65490;
  localparam logic [3:0]  COMPARES_RST       = 4'd6;

  localparam logic [7:0]  BAD_COUNT_MAX = 8'd255;
  localparam logic [17:0] DISTANCE_MAX  = 18'd142177;

  // floor(ticks*256/118) == (ticks * ceil(2^29/59)) >> 22, exact for 16-bit ticks
  localparam logic [23:0] Q8_RECIP = 24'd9099507;
  localparam int unsigned Q8_SHIFT = 22;

endpackage

/* rtl/core/sonar_echo_ranger_top.sv */
// Sonar echo ranger: two-stage pipeline. Stage one applies one event to the
// ranging state; stage two scales the selected width to distance in Q8.
// Path: an accepted item is registered in s1_r, then its scaled result in out_r.
// Throughput: one item per cycle; the output register stall holds both stages.
// Reset: synchronous active-low rst_n clears state, loads register defaults.
// Depends on ser_pkg.
module sonar_echo_ranger_top
  import ser_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  in_item_t          in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output out_item_t         out_data,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [ADDR_W-1:0] cfg_paddr,
  input  logic [31:0]       cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready
);

  typedef struct packed {
    logic        trigger_level;
    logic        reading_ready;
    logic [15:0] ticks;
    source_t     source;
  } s1_item_t;

  logic [15:0] min_ticks_r, max_ticks_r, fallback_ticks_r;
  logic [7:0]  error_limit_r;
  logic [3:0]  compares_r;

  logic        measure_done_r, measure_done_nxt;
  logic [15:0] pulse_width_r, pulse_width_nxt;
  logic [15:0] start_count_r, start_count_nxt;
  logic [15:0] last_good_r, last_good_nxt;
  logic [7:0]  bad_count_r, bad_count_nxt;
  logic [2:0]  divider_r, divider_nxt;
  logic        trigger_r, trigger_nxt;

  logic        s1_valid_r;
  s1_item_t    s1_r, s1_nxt;
  logic        out_valid_r;
  out_item_t   out_r;

  logic        advance, in_accept, cfg_write;
  reg_idx_t    cfg_idx;
  logic [3:0]  reload;
  logic [15:0] periods;
  logic        bad;
  logic [39:0] scaled;

  assign cfg_pready = 1'b1;
  assign cfg_idx    = reg_idx_t'(cfg_paddr[ADDR_W-1:2]);
  assign cfg_write  = cfg_psel && cfg_penable && cfg_pwrite;

  always_comb begin
    cfg_prdata = '0;
    case (cfg_idx)
      REG_MIN_TICKS:      cfg_prdata = {16'd0, min_ticks_r};
      REG_MAX_TICKS:      cfg_prdata = {16'd0, max_ticks_r};
      REG_ERROR_LIMIT:    cfg_prdata = {24'd0, error_limit_r};
      REG_FALLBACK_TICKS: cfg_prdata = {16'd0, fallback_ticks_r};
      REG_COMPARES:       cfg_prdata = {28'd0, compares_r};
      default:            cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_ticks_r      <= MIN_TICKS_RST;
      max_ticks_r      <= MAX_TICKS_RST;
      error_limit_r    <= ERROR_LIMIT_RST;
      fallback_ticks_r <= FALLBACK_TICKS_RST;
      compares_r       <= COMPARES_RST;
    end else if (cfg_write) begin
      unique case (cfg_idx)
        REG_MIN_TICKS:      min_ticks_r      <= cfg_pwdata[15:0];
        REG_MAX_TICKS:      max_ticks_r      <= cfg_pwdata[15:0];
        REG_ERROR_LIMIT:    error_limit_r    <= cfg_pwdata[7:0];
        REG_FALLBACK_TICKS: fallback_ticks_r <= cfg_pwdata[15:0];
        REG_COMPARES:       compares_r       <= cfg_pwdata[3:0];
        default: ;
      endcase
    end
  end

  // clamp reload to 1..8
  always_comb begin
    if (compares_r == 4'd0) begin
      reload = 4'd1;
    end else if (compares_r > 4'd8) begin
      reload = 4'd8;
    end else begin
      reload = compares_r;
    end
  end

  assign advance   = !out_valid_r || out_ready;
  assign in_ready  = advance;
  assign in_accept = in_valid && in_ready;

  assign periods = {12'd0, reload} - 16'd1 - {13'd0, divider_r};
  assign bad     = (pulse_width_r < min_ticks_r) || (pulse_width_r > max_ticks_r);

  always_comb begin
    measure_done_nxt = measure_done_r;
    pulse_width_nxt  = pulse_width_r;
    start_count_nxt  = start_count_r;
    last_good_nxt    = last_good_r;
    bad_count_nxt    = bad_count_r;
    divider_nxt      = divider_r;
    trigger_nxt      = trigger_r;
    s1_nxt.reading_ready = 1'b0;
    s1_nxt.ticks         = '0;
    s1_nxt.source        = SRC_FRESH;
    unique case (in_data.mode)
      MODE_TICK: begin
        if (divider_r == 3'd0) begin
          if (!measure_done_r) begin
            pulse_width_nxt = '0;
          end
          measure_done_nxt = 1'b0;
          trigger_nxt      = 1'b1;
          divider_nxt      = 3'(reload - 4'd1);
        end else begin
          divider_nxt = divider_r - 3'd1;
        end
      end
      MODE_OVERFLOW: begin
        trigger_nxt = 1'b0;
      end
      MODE_ECHO: begin
        if (!measure_done_r) begin
          if (in_data.echo_level) begin
            start_count_nxt = in_data.timer_count;
          end else begin
            pulse_width_nxt  = in_data.timer_count - periods - start_count_r;
            measure_done_nxt = 1'b1;
          end
        end
      end
      MODE_READ: begin
        s1_nxt.reading_ready = 1'b1;
        if (bad && (last_good_r != 16'd0)) begin
          if (bad_count_r > error_limit_r) begin
            s1_nxt.ticks  = fallback_ticks_r;
            s1_nxt.source = SRC_FALLBACK;
          end else begin
            if (bad_count_r != BAD_COUNT_MAX) begin
              bad_count_nxt = bad_count_r + 8'd1;
            end
            s1_nxt.ticks  = last_good_r;
            s1_nxt.source = SRC_PREVIOUS;
          end
        end else begin
          bad_count_nxt = '0;
          last_good_nxt = pulse_width_r;
          s1_nxt.ticks  = pulse_width_r;
          s1_nxt.source = SRC_FRESH;
        end
      end
      default: ;
    endcase
    s1_nxt.trigger_level = trigger_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      measure_done_r <= 1'b0;
      pulse_width_r  <= '0;
      start_count_r  <= '0;
      last_good_r    <= '0;
      bad_count_r    <= '0;
      divider_r      <= '0;
      trigger_r      <= 1'b0;
    end else if (in_accept) begin
      measure_done_r <= measure_done_nxt;
      pulse_width_r  <= pulse_width_nxt;
      start_count_r  <= start_count_nxt;
      last_good_r    <= last_good_nxt;
      bad_count_r    <= bad_count_nxt;
      divider_r      <= divider_nxt;
      trigger_r      <= trigger_nxt;
    end
  end

  assign scaled = {24'd0, s1_r.ticks} * {16'd0, Q8_RECIP};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (advance) begin
      s1_valid_r  <= in_valid;
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_r                <= s1_nxt;
      out_r.trigger_level <= s1_r.trigger_level;
      out_r.reading_ready <= s1_r.reading_ready;
      out_r.distance_q8   <= scaled[Q8_SHIFT +: 18];
      out_r.source        <= s1_r.source;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

/* rtl/core/ser_checker.sv */
// Port-level checker for the sonar echo ranger, bound to the top level.
// Depends on ser_pkg and sonar_echo_ranger_top.
module ser_checker
  import ser_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input out_item_t         out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result item changed or dropped");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output register");

  a_non_read_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.reading_ready |->
      out_data.distance_q8 == '0 && out_data.source == SRC_FRESH)
    else $error("non-read item carries a distance");

  a_distance_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.distance_q8 <= DISTANCE_MAX &&
      (out_data.source == SRC_FRESH || out_data.source == SRC_PREVIOUS ||
       out_data.source == SRC_FALLBACK))
    else $error("distance or source out of range");

endmodule

bind sonar_echo_ranger_top ser_checker u_ser_checker (.*);
